[design/tone_oscillator_resistor_dac_top_macros.svh]
// Assertion macros for the tone oscillator top level.
`ifndef TONE_OSCILLATOR_RESISTOR_DAC_TOP_MACROS_SVH
`define TONE_OSCILLATOR_RESISTOR_DAC_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge, skipped while reset is asserted.
`define TORD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define TORD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define TORD_ASSERT(lbl, clk, rst_n, prop)

`define TORD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[design/tord_pkg.sv]
// Constants and widths for the tone oscillator with resistor-divider output.
`timescale 1ns / 1ps

package tord_pkg;

    // Phase accumulator width (unsigned fraction of one tone cycle).
    localparam int PHASE_BITS = 32;

    // Field and register widths.
    localparam int PITCH_BITS    = 8;
    localparam int SAMPLE_BITS   = 16;
    localparam int SR_BITS       = 18;
    localparam int GAIN_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 18;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN        = 2'd1;

    // Register reset values.
    localparam logic [SR_BITS-1:0]   SR_RESET   = 18'd44100;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd6554;

    // Pitch code that silences the oscillator.
    localparam logic [PITCH_BITS-1:0] PITCH_SILENT = 8'hFF;

    // Tone numerator: frequency = TONE_NUM / (256 - pitch_code).
    localparam int TONE_NUM = 96000;
    localparam int NUM_BITS = $clog2(TONE_NUM + 1);

    // Period (256 - pitch_code) and divisor widths.
    localparam int PERIOD_BITS = PITCH_BITS + 1;
    localparam int DEN_BITS    = PERIOD_BITS + SR_BITS;

    // Restoring division: one quotient bit per cycle over the numerator
    // bits followed by PHASE_BITS fraction bits.
    localparam int DIV_STEPS = NUM_BITS + PHASE_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    // Resistor-divider weights, unsigned Q0.16.
    localparam logic [SAMPLE_BITS-1:0] W_BIT0    = 16'd8773;
    localparam logic [SAMPLE_BITS-1:0] W_BIT2_LO = 16'd12333;
    localparam logic [SAMPLE_BITS-1:0] W_BIT2_HI = 16'd27911;
    localparam logic [SAMPLE_BITS-1:0] W_BIT3    = 16'd16629;

    // Rounding constant for the Q0.16 product.
    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam logic [PROD_BITS:0] ROUND_HALF = 33'd32768;

endpackage

[design/tone_oscillator_resistor_dac_top.sv]
// Top level of the tone oscillator with a resistor-divider output stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per
//   audio sample tick: pitch code and the two volume switches. Output
//   channel (o_out_valid / i_out_stall) returns one sample per input.
//   A transaction moves on an edge with valid high and stall low.
//   Configuration: i_cfg_we writes i_cfg_data to the register at
//   i_cfg_index (0 sample_rate, 1 gain); other indexes are ignored.
//   Write only while the block is idle.
// Sequencing:
//   After acceptance in S_IDLE, a toned sample passes S_MUL, then the
//   bit-serial restoring divider in S_DIV, which forms the phase increment
//   one quotient bit per cycle, then S_DONE. A silent pitch, or a zero
//   sample rate, skips the divider and goes from S_MUL straight to S_DONE.
//   One transaction is in work at a time; the next is taken as soon as
//   the previous result sits in the output register.
// Reset: phase goes to zero, registers take their defaults, no output.
// Stall: an untaken result waits in the output register; the next waits in
//   the final state until that register frees; toned ones then advance phase.
`timescale 1ns / 1ps
`include "tone_oscillator_resistor_dac_top_macros.svh"

module tone_oscillator_resistor_dac_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tord_pkg::PITCH_BITS-1:0]     i_pitch_code,
    input  logic                                i_volume_low,
    input  logic                                i_volume_high,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tord_pkg::SAMPLE_BITS-1:0]    o_sample,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic [tord_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tord_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    // control state
    t_state                              r_state,       n_state;
    logic                                r_out_valid,   n_out_valid;
    logic [tord_pkg::PHASE_BITS-1:0]     r_phase,       n_phase;
    logic [tord_pkg::SR_BITS-1:0]        r_sample_rate, n_sample_rate;
    logic [tord_pkg::GAIN_BITS-1:0]      r_gain,        n_gain;
    logic [tord_pkg::STEP_BITS-1:0]      r_step,        n_step;
    logic                                r_upd,         n_upd;

    // payload
    logic [3:0]                          r_count,       n_count;
    logic                                r_vol_lo,      n_vol_lo;
    logic                                r_vol_hi,      n_vol_hi;
    logic                                r_silent,      n_silent;
    logic [tord_pkg::PERIOD_BITS-1:0]    r_period,      n_period;
    logic [tord_pkg::DEN_BITS-1:0]       r_den,         n_den;
    logic [tord_pkg::DEN_BITS-1:0]       r_rem,         n_rem;
    logic [tord_pkg::NUM_BITS-1:0]       r_num,         n_num;
    logic [tord_pkg::PHASE_BITS-1:0]     r_quo,         n_quo;
    logic [tord_pkg::SAMPLE_BITS-1:0]    r_level,       n_level;
    logic [tord_pkg::SAMPLE_BITS-1:0]    r_sample,      n_sample;

    // datapath terms
    logic [tord_pkg::SAMPLE_BITS-1:0]    w_sum;
    logic [tord_pkg::PROD_BITS-1:0]      w_prod;
    logic [tord_pkg::PROD_BITS:0]        w_round;
    logic [tord_pkg::SAMPLE_BITS:0]      w_scaled;
    logic [tord_pkg::DEN_BITS:0]         w_rem_sh;
    logic [tord_pkg::DEN_BITS:0]         w_rem_sub;
    logic                                w_qbit;
    logic                                w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // Divider weight sum from the counter bits and volume switches.
    always_comb begin
        w_sum = '0;
        if (r_count[0]) begin
            w_sum = w_sum + tord_pkg::W_BIT0;
        end
        if (r_count[2]) begin
            w_sum = w_sum + (r_vol_lo ? tord_pkg::W_BIT2_HI : tord_pkg::W_BIT2_LO);
        end
        if (r_count[3] && r_vol_hi) begin
            w_sum = w_sum + tord_pkg::W_BIT3;
        end
    end

    // Scale by gain, round half up, saturate.
    assign w_prod   = tord_pkg::PROD_BITS'(w_sum) * tord_pkg::PROD_BITS'(r_gain);
    assign w_round  = (tord_pkg::PROD_BITS + 1)'(w_prod) + tord_pkg::ROUND_HALF;
    assign w_scaled = w_round[tord_pkg::PROD_BITS -: (tord_pkg::SAMPLE_BITS + 1)];

    // One restoring division step: bring down the next numerator bit.
    assign w_rem_sh  = {r_rem, r_num[tord_pkg::NUM_BITS-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_den});

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_phase       = r_phase;
        n_sample_rate = r_sample_rate;
        n_gain        = r_gain;
        n_step        = r_step;
        n_upd         = r_upd;
        n_count       = r_count;
        n_vol_lo      = r_vol_lo;
        n_vol_hi      = r_vol_hi;
        n_silent      = r_silent;
        n_period      = r_period;
        n_den         = r_den;
        n_rem         = r_rem;
        n_num         = r_num;
        n_quo         = r_quo;
        n_level       = r_level;
        n_sample      = r_sample;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                tord_pkg::CFG_SAMPLE_RATE: n_sample_rate = i_cfg_data[tord_pkg::SR_BITS-1:0];
                tord_pkg::CFG_GAIN:        n_gain = i_cfg_data[tord_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end

        // drop the output once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // counter value comes from the phase before the advance
                    n_count  = r_phase[tord_pkg::PHASE_BITS-1 -: 4];
                    n_vol_lo = i_volume_low;
                    n_vol_hi = i_volume_high;
                    n_silent = (i_pitch_code == tord_pkg::PITCH_SILENT);
                    n_period = (tord_pkg::PERIOD_BITS)'(1 << tord_pkg::PITCH_BITS)
                             - {1'b0, i_pitch_code};
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_den   = tord_pkg::DEN_BITS'(r_period) * tord_pkg::DEN_BITS'(r_sample_rate);
                n_level = w_scaled[tord_pkg::SAMPLE_BITS] ? '1
                        : w_scaled[tord_pkg::SAMPLE_BITS-1:0];
                n_rem   = '0;
                n_num   = tord_pkg::NUM_BITS'(tord_pkg::TONE_NUM);
                n_quo   = '0;
                n_step  = tord_pkg::STEP_BITS'(tord_pkg::DIV_STEPS - 1);
                if (r_silent) begin
                    // silence: zero output, hold phase
                    n_level = '0;
                    n_upd   = 1'b0;
                    n_state = S_DONE;
                end else if (r_sample_rate == '0) begin
                    // zero rate: no increment
                    n_upd   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_upd   = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_qbit ? w_rem_sub[tord_pkg::DEN_BITS-1:0]
                               : w_rem_sh[tord_pkg::DEN_BITS-1:0];
                n_num = {r_num[tord_pkg::NUM_BITS-2:0], 1'b0};
                // upper quotient bits fall off: increment wraps modulo one
                n_quo = {r_quo[tord_pkg::PHASE_BITS-2:0], w_qbit};
                if (r_step == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_sample    = r_level;
                    if (r_upd) begin
                        n_phase = r_phase + r_quo;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_phase       <= '0;
            r_sample_rate <= tord_pkg::SR_RESET;
            r_gain        <= tord_pkg::GAIN_RESET;
            r_step        <= '0;
            r_upd         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_phase       <= n_phase;
            r_sample_rate <= n_sample_rate;
            r_gain        <= n_gain;
            r_step        <= n_step;
            r_upd         <= n_upd;
            r_count       <= n_count;
            r_vol_lo      <= n_vol_lo;
            r_vol_hi      <= n_vol_hi;
            r_silent      <= n_silent;
            r_period      <= n_period;
            r_den         <= n_den;
            r_rem         <= n_rem;
            r_num         <= n_num;
            r_quo         <= n_quo;
            r_level       <= n_level;
            r_sample      <= n_sample;
        end
    end

    // A new result only appears out of the final state.
    `TORD_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE))

    // Phase moves only when a toned transaction completes.
    `TORD_ASSERT_ALWAYS(a_phase_hold, i_clk,
        (i_rst_n && $past(i_rst_n) && !$stable(r_phase)) |-> $past(r_state == S_DONE && r_upd))

    // Phase advances only after a division by a nonzero divisor.
    `TORD_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DONE && r_upd) |-> (r_den != '0))

    // An accepted transaction blocks the input on the next cycle.
    `TORD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)

endmodule

[test/tb_tone_oscillator_resistor_dac_top.sv]
// Self-checking testbench for the tone oscillator with resistor-divider output.
`timescale 1ns / 1ps

module tb_tone_oscillator_resistor_dac_top;
    import tord_pkg::*;

    // Drain pause after the last sample.
    localparam int DRAIN_CYCLES = 64;
    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT  = 1000000;
    // Long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES  = 400;
    // Items per random phase and number of random phases.
    localparam int PHASE_ITEMS  = 200;
    localparam int RAND_PHASES  = 8;

    // Register indexes with no register behind them; the block ignores them.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_3 = 2'd3;

    typedef struct packed {
        logic [PITCH_BITS-1:0] pitch;
        logic                  vol_lo;
        logic                  vol_hi;
    } tone_req_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [PITCH_BITS-1:0]    i_pitch_code = '0;
    logic                     i_volume_low = 1'b0;
    logic                     i_volume_high = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [SAMPLE_BITS-1:0]   o_sample;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // Shadow of the block: registers and phase accumulator.
    logic [SR_BITS-1:0]       cfg_rate  = SR_RESET;
    logic [GAIN_BITS-1:0]     cfg_gain  = GAIN_RESET;
    logic [PHASE_BITS-1:0]    osc_phase = '0;

    tone_req_t                tone_reqs[$];    // items waiting for the driver
    logic [SAMPLE_BITS-1:0]   due_samples[$];  // predicted samples, oldest first
    tone_req_t                next_req;
    logic [SAMPLE_BITS-1:0]   want;

    int unsigned issued_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned errors         = 0;
    int unsigned cycles         = 0;
    int unsigned hold_left      = 0;
    bit          hold_pending   = 1'b0;
    bit          steady         = 1'b0;  // no idling on either side

    tone_oscillator_resistor_dac_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pitch_code  (i_pitch_code),
        .i_volume_low  (i_volume_low),
        .i_volume_high (i_volume_high),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample      (o_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Divider level for one counter value, scaled by gain, rounded half up, saturated.
    function automatic logic [SAMPLE_BITS-1:0] dac_level(input logic [3:0] count,
                                                         input logic vol_lo,
                                                         input logic vol_hi,
                                                         input logic [GAIN_BITS-1:0] g);
        logic [SAMPLE_BITS+1:0] sum;
        logic [PROD_BITS+1:0]   prod;
        sum = '0;
        if (count[0])
            sum = sum + W_BIT0;
        // bit 2 goes through 22k, or 22k parallel 10k with the low volume switch
        if (count[2])
            sum = sum + (vol_lo ? W_BIT2_HI : W_BIT2_LO);
        if (count[3] && vol_hi)
            sum = sum + W_BIT3;
        prod = sum * g + ROUND_HALF;
        prod = prod >> SAMPLE_BITS;
        return (prod > {SAMPLE_BITS{1'b1}}) ? {SAMPLE_BITS{1'b1}} : prod[SAMPLE_BITS-1:0];
    endfunction

    // Phase step per sample: tone frequency over sample rate, wrapped to one cycle.
    function automatic logic [PHASE_BITS-1:0] phase_advance(input logic [PITCH_BITS-1:0] pitch,
                                                            input logic [SR_BITS-1:0] rate);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = TONE_NUM;
        num = num << PHASE_BITS;
        den = ((64'd1 << PITCH_BITS) - pitch) * rate;
        quo = num / den;
        return quo[PHASE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Write one register; the shadow copy is updated as the write is driven.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_SAMPLE_RATE: cfg_rate = data[SR_BITS-1:0];
            CFG_GAIN:        cfg_gain = data[GAIN_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_tone(input logic [PITCH_BITS-1:0] pitch, input logic vol_lo,
                             input logic vol_hi);
        tone_reqs.push_back('{pitch: pitch, vol_lo: vol_lo, vol_hi: vol_hi});
        issued_items++;
    endtask

    // Hold until every issued transaction is in and every sample is out,
    // then let the block settle before touching its registers.
    task automatic wait_drained();
        while (accepted_items != issued_items || due_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: hold a stalled transaction, otherwise offer the next
    // pending item or idle at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (tone_reqs.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
                next_req = tone_reqs.pop_front();
                i_in_valid    <= 1'b1;
                i_pitch_code  <= next_req.pitch;
                i_volume_low  <= next_req.vol_lo;
                i_volume_high <= next_req.vol_hi;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99) < 38);
        end
    end

    // Monitor: check each sample taken, then predict for each transaction taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with nothing expected", o_sample));
                end else begin
                    want = due_samples.pop_front();
                    if (o_sample !== want)
                        report_mismatch($sformatf("sample %0d, expected %0d", o_sample, want));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                accepted_items++;
                if (i_pitch_code == PITCH_SILENT) begin
                    // silence: zero output, phase frozen
                    due_samples.push_back('0);
                end else begin
                    // counter value is read before the phase advances
                    due_samples.push_back(dac_level(osc_phase[PHASE_BITS-1 -: 4], i_volume_low,
                                                    i_volume_high, cfg_gain));
                    if (cfg_rate != 0)
                        osc_phase = osc_phase + phase_advance(i_pitch_code, cfg_rate);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_tone_oscillator_resistor_dac_top failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_SAMPLE_RATE;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: field extremes, all volume combinations, silence.
        push_tone(8'd0, 1'b0, 1'b0);
        push_tone(8'd0, 1'b1, 1'b0);
        push_tone(8'd0, 1'b0, 1'b1);
        push_tone(8'd0, 1'b1, 1'b1);
        push_tone(8'd254, 1'b1, 1'b1);
        push_tone(PITCH_SILENT, 1'b1, 1'b1);
        push_tone(8'd128, 1'b1, 1'b0);
        push_tone(8'd85, 1'b0, 1'b1);
        push_tone(8'd170, 1'b1, 1'b1);
        push_tone(8'd1, 1'b1, 1'b1);
        push_tone(PITCH_SILENT, 1'b0, 1'b0);
        push_tone(8'd200, 1'b1, 1'b1);
        wait_drained();

        // Lowest nominal rate at full gain, upper data bits set on the gain
        // write; high pitches put the tone above the sample rate and wrap.
        write_reg(CFG_SAMPLE_RATE, 18'd8000);
        write_reg(CFG_GAIN, {2'b11, 16'hFFFF});
        push_tone(8'd254, 1'b1, 1'b1);
        push_tone(8'd253, 1'b1, 1'b1);
        push_tone(8'd250, 1'b0, 1'b1);
        push_tone(8'd245, 1'b1, 1'b0);
        push_tone(8'd254, 1'b1, 1'b1);
        push_tone(8'd240, 1'b1, 1'b1);
        wait_drained();

        // Zero sample rate: phase stays put, samples come from the held phase.
        write_reg(CFG_SAMPLE_RATE, 18'd0);
        write_reg(CFG_GAIN, 18'd40000);
        push_tone(8'd100, 1'b1, 1'b1);
        push_tone(8'd0, 1'b0, 1'b1);
        push_tone(PITCH_SILENT, 1'b1, 1'b0);
        push_tone(8'd254, 1'b1, 1'b1);
        wait_drained();

        // Unused indexes must leave both registers alone; then the
        // widest rate and zero gain.
        write_reg(CFG_UNUSED_2, 18'($urandom));
        write_reg(CFG_UNUSED_3, 18'($urandom));
        push_tone(8'd254, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_SAMPLE_RATE, {SR_BITS{1'b1}});
        write_reg(CFG_GAIN, 18'd0);
        push_tone(8'd0, 1'b1, 1'b1);
        push_tone(8'd254, 1'b1, 1'b1);
        wait_drained();

        // Random phases, each with its own settings; one runs with no idling
        // and one starts with a long receiver hold-off.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph % 4 == 3)
                write_reg(CFG_SAMPLE_RATE, 18'($urandom_range(0, (1 << SR_BITS) - 1)));
            else
                write_reg(CFG_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
            write_reg(CFG_GAIN, 18'($urandom_range(0, (1 << GAIN_BITS) - 1)));
            steady = (ph == 2);
            if (ph == 5)
                hold_pending = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 8)
                    push_tone(PITCH_SILENT, 1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                    push_tone(8'($urandom_range(0, 254)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
            wait_drained();
            steady = 1'b0;
        end

        if (errors == 0)
            $display("tb_tone_oscillator_resistor_dac_top passed");
        else
            $display("tb_tone_oscillator_resistor_dac_top failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/tord_pkg.sv
design/tone_oscillator_resistor_dac_top.sv
test/tb_tone_oscillator_resistor_dac_top.sv
